// File: rtl/ufs_inode_disk_offset_core_defines.svh
// Assertion macros shared by the checker of the inode offset core.
// Depends on nothing; included by rtl/ufs_ido_checker.sv.
`ifndef UFS_INODE_DISK_OFFSET_CORE_DEFINES_SVH
`define UFS_INODE_DISK_OFFSET_CORE_DEFINES_SVH

// Same-cycle implication, masked while reset is active.
`define UFS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is active.
`define UFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define UFS_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ufs_ido_pkg.sv
`timescale 1ns / 1ps
// Types and constants of the inode offset core.
// No dependencies; used by rtl/ufs_inode_disk_offset_core.sv.
package ufs_ido_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 48;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INODES_PER_GROUP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAGS_PER_GROUP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INODES_PER_BLOCK = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATION_DELTA   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CYCLE_MASK       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INODE_AREA       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FRAGMENT_BYTES   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SLICE_BASE       = 3'd7;

  localparam int IPB_W = 11;

  // After group start products and inode area term
  typedef struct packed {
    logic [63:0]      p_group;
    logic [63:0]      p_rot;
    logic [63:0]      area;
    logic [IPB_W-1:0] slot;
    logic             err;
  } s1_t;

  // Fragment address
  typedef struct packed {
    logic [63:0]      frag;
    logic [IPB_W-1:0] slot;
    logic             err;
  } s2_t;

  // Partial products of fragment times fragment size, plus slice base and slot bytes
  typedef struct packed {
    logic [48:0] m_lo;
    logic [31:0] m_hi;
    logic [63:0] base;
    logic        err;
  } s3_t;

  // Final result
  typedef struct packed {
    logic [63:0] offset;
    logic        err;
  } s4_t;

endpackage

// File: rtl/ufs_ido_div_cell.sv
`timescale 1ns / 1ps
// One restoring-division cell: resolves one quotient bit per request.
// No dependencies; chained by rtl/ufs_inode_disk_offset_core.sv.
module ufs_ido_div_cell #(
  parameter int RW = 32,
  parameter int NW = 32,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [RW-1:0] in_rem,
  input  logic [NW-1:0] in_num,
  input  logic [SW-1:0] in_side,
  input  logic [RW-1:0] divisor,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [RW-1:0] out_rem,
  output logic [NW-1:0] out_num,
  output logic [SW-1:0] out_side
);

  logic          valid_r;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [NW-1:0] num_r, num_nxt;
  logic [SW-1:0] side_r;
  logic [RW:0]   trial, diff;
  logic          fits;

  // Shift in the next dividend bit, subtract when it fits
  always_comb begin
    trial   = {in_rem, in_num[NW-1]};
    diff    = trial - {1'b0, divisor};
    fits    = (trial >= {1'b0, divisor});
    rem_nxt = fits ? diff[RW-1:0] : trial[RW-1:0];
    num_nxt = {in_num[NW-2:0], fits};
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      rem_r  <= rem_nxt;
      num_r  <= num_nxt;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_num   = num_r;
  assign out_side  = side_r;

endmodule

// File: rtl/ufs_ido_stage.sv
`timescale 1ns / 1ps
// Pipeline register with valid/ready flow control.
// No dependencies; used by rtl/ufs_inode_disk_offset_core.sv.
module ufs_ido_stage #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  logic         valid_r;
  logic [W-1:0] data_r;

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Payload loads only on an accepted request
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= in_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// File: rtl/ufs_inode_disk_offset_core.sv
`timescale 1ns / 1ps
// Inode number to byte offset core: top level.
// Depends on ufs_ido_pkg, ufs_ido_div_cell and ufs_ido_stage.
//
// Usage:
//   The cfg channel writes register cfg_index with cfg_data; cfg_ready is
//   always high. Write registers only while no request is in flight.
//   The in channel takes one inode number per request in in_tdata[31:0].
//   The out channel returns the byte offset in out_tdata and the
//   configuration error flag in out_tuser (offset is 0 when it is set).
// Pipeline: from input accept to output valid, 32 division cells split
//   the number into group and index, 32 more cells split the index into
//   block and slot, then four arithmetic stages (products, fragment sum,
//   fragment-size partial products, final sum) follow.
// Throughput: one request per cycle while out_tready is high; every cell
//   and stage holds one request and hands it on each cycle unless stalled.
// Reset: all pipeline valids and configuration registers clear to zero.
// Stall: while out_tready is low each stage holds once the one after it
//   is full; empty stages keep filling, so in_tready stays high until the
//   whole chain is occupied.
module ufs_inode_disk_offset_core #(
  parameter int INODE_BYTES        = 128,
  parameter int FRAGS_PER_BLK_LOG2 = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [ufs_ido_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ufs_ido_pkg::CFG_DATA_W-1:0] cfg_data,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] inode_number
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] byte_offset
  output logic        out_tuser   // [0] config_error
);

  localparam int NCELL = 32;
  localparam int IPB_W = ufs_ido_pkg::IPB_W;

  // Configuration registers
  logic [31:0]      ipg_r, fpg_r, delta_r, cmask_r, area_r;
  logic [IPB_W-1:0] ipb_r;
  logic [16:0]      fbytes_r;
  logic [47:0]      sbase_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ipg_r    <= '0;
      fpg_r    <= '0;
      ipb_r    <= '0;
      delta_r  <= '0;
      cmask_r  <= '0;
      area_r   <= '0;
      fbytes_r <= '0;
      sbase_r  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        ufs_ido_pkg::REG_INODES_PER_GROUP: ipg_r    <= cfg_data[31:0];
        ufs_ido_pkg::REG_FRAGS_PER_GROUP:  fpg_r    <= cfg_data[31:0];
        ufs_ido_pkg::REG_INODES_PER_BLOCK: ipb_r    <= cfg_data[IPB_W-1:0];
        ufs_ido_pkg::REG_ROTATION_DELTA:   delta_r  <= cfg_data[31:0];
        ufs_ido_pkg::REG_CYCLE_MASK:       cmask_r  <= cfg_data[31:0];
        ufs_ido_pkg::REG_INODE_AREA:       area_r   <= cfg_data[31:0];
        ufs_ido_pkg::REG_FRAGMENT_BYTES:   fbytes_r <= cfg_data[16:0];
        ufs_ido_pkg::REG_SLICE_BASE:       sbase_r  <= cfg_data[47:0];
        default: ;
      endcase
    end
  end

  logic cfg_err;
  assign cfg_err = (ipg_r == '0) || (fpg_r == '0) || (ipb_r == '0);

  // Chain A: inode number / inodes per group
  logic             a_vld [NCELL+1];
  logic             a_rdy [NCELL+1];
  logic [31:0]      a_rem [NCELL+1];
  logic [31:0]      a_num [NCELL+1];
  logic             a_err [NCELL+1];

  assign a_vld[0]  = in_tvalid;
  assign in_tready = a_rdy[0];
  assign a_rem[0]  = '0;
  assign a_num[0]  = in_tdata;
  assign a_err[0]  = cfg_err;

  for (genvar i = 0; i < NCELL; i++) begin : g_chain_a
    ufs_ido_div_cell #(.RW(32), .NW(32), .SW(1)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (a_vld[i]),
      .in_ready (a_rdy[i]),
      .in_rem   (a_rem[i]),
      .in_num   (a_num[i]),
      .in_side  (a_err[i]),
      .divisor  (ipg_r),
      .out_valid(a_vld[i+1]),
      .out_ready(a_rdy[i+1]),
      .out_rem  (a_rem[i+1]),
      .out_num  (a_num[i+1]),
      .out_side (a_err[i+1])
    );
  end

  // Chain B: index within group / inodes per block; group rides along
  logic             b_vld  [NCELL+1];
  logic             b_rdy  [NCELL+1];
  logic [IPB_W-1:0] b_rem  [NCELL+1];
  logic [31:0]      b_num  [NCELL+1];
  logic [32:0]      b_side [NCELL+1];

  assign b_vld[0]      = a_vld[NCELL];
  assign a_rdy[NCELL]  = b_rdy[0];
  assign b_rem[0]      = '0;
  assign b_num[0]      = a_rem[NCELL];
  assign b_side[0]     = {a_num[NCELL], a_err[NCELL]};

  for (genvar i = 0; i < NCELL; i++) begin : g_chain_b
    ufs_ido_div_cell #(.RW(IPB_W), .NW(32), .SW(33)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (b_vld[i]),
      .in_ready (b_rdy[i]),
      .in_rem   (b_rem[i]),
      .in_num   (b_num[i]),
      .in_side  (b_side[i]),
      .divisor  (ipb_r),
      .out_valid(b_vld[i+1]),
      .out_ready(b_rdy[i+1]),
      .out_rem  (b_rem[i+1]),
      .out_num  (b_num[i+1]),
      .out_side (b_side[i+1])
    );
  end

  // Stage 1: group products and inode area term
  ufs_ido_pkg::s1_t s1_d, s1_q;
  logic             s1_vld, s1_rdy;
  logic [31:0]      grp, sel;

  always_comb begin
    grp          = b_side[NCELL][32:1];
    sel          = grp & ~cmask_r;
    s1_d.p_group = 64'(fpg_r) * 64'(grp);
    s1_d.p_rot   = 64'(delta_r) * 64'(sel);
    s1_d.area    = (64'(b_num[NCELL]) << FRAGS_PER_BLK_LOG2) + 64'(area_r);
    s1_d.slot    = b_rem[NCELL];
    s1_d.err     = b_side[NCELL][0];
  end

  ufs_ido_stage #(.W($bits(ufs_ido_pkg::s1_t))) u_s1 (
    .clk(clk), .rst_n(rst_n),
    .in_valid(b_vld[NCELL]), .in_ready(b_rdy[NCELL]), .in_data(s1_d),
    .out_valid(s1_vld), .out_ready(s1_rdy), .out_data(s1_q)
  );

  // Stage 2: fragment address
  ufs_ido_pkg::s2_t s2_d, s2_q;
  logic             s2_vld, s2_rdy;

  always_comb begin
    s2_d.frag = s1_q.p_group + s1_q.p_rot + s1_q.area;
    s2_d.slot = s1_q.slot;
    s2_d.err  = s1_q.err;
  end

  ufs_ido_stage #(.W($bits(ufs_ido_pkg::s2_t))) u_s2 (
    .clk(clk), .rst_n(rst_n),
    .in_valid(s1_vld), .in_ready(s1_rdy), .in_data(s2_d),
    .out_valid(s2_vld), .out_ready(s2_rdy), .out_data(s2_q)
  );

  // Stage 3: split fragment product, slice base plus slot bytes
  ufs_ido_pkg::s3_t s3_d, s3_q;
  logic             s3_vld, s3_rdy;

  always_comb begin
    s3_d.m_lo = 49'(s2_q.frag[31:0]) * 49'(fbytes_r);
    s3_d.m_hi = 32'(s2_q.frag[63:32] * 32'(fbytes_r));
    s3_d.base = 64'(sbase_r) + 64'(s2_q.slot) * 64'(INODE_BYTES);
    s3_d.err  = s2_q.err;
  end

  ufs_ido_stage #(.W($bits(ufs_ido_pkg::s3_t))) u_s3 (
    .clk(clk), .rst_n(rst_n),
    .in_valid(s2_vld), .in_ready(s2_rdy), .in_data(s3_d),
    .out_valid(s3_vld), .out_ready(s3_rdy), .out_data(s3_q)
  );

  // Stage 4: final sum, forced to zero on a configuration error
  ufs_ido_pkg::s4_t s4_d, s4_q;

  always_comb begin
    s4_d.offset = s3_q.err ? '0
                : s3_q.base + 64'(s3_q.m_lo) + {s3_q.m_hi, 32'b0};
    s4_d.err    = s3_q.err;
  end

  ufs_ido_stage #(.W($bits(ufs_ido_pkg::s4_t))) u_s4 (
    .clk(clk), .rst_n(rst_n),
    .in_valid(s3_vld), .in_ready(s3_rdy), .in_data(s4_d),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_data(s4_q)
  );

  assign out_tdata = s4_q.offset;
  assign out_tuser = s4_q.err;

endmodule

// File: rtl/ufs_ido_checker.sv
`timescale 1ns / 1ps
// Port-level checker of the inode offset core, bound to the top level.
// Depends on ufs_inode_disk_offset_core_defines.svh.
`include "ufs_inode_disk_offset_core_defines.svh"

module ufs_ido_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic        out_tuser
);

  // Error results carry a zero offset
  `UFS_ASSERT_NOW(a_err_zero, out_tvalid && out_tuser, out_tdata == 64'd0, "error with offset")

  // Config writes never stall
  `UFS_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "cfg write stalled")

  // Reset empties the pipeline
  `UFS_ASSERT_RST(a_rst_empty, !rst_n, !out_tvalid, "valid after reset")

  // Stalled result holds
  `UFS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
                   out_tvalid && $stable(out_tdata), "stalled result changed")

endmodule

bind ufs_inode_disk_offset_core ufs_ido_checker u_ufs_ido_checker (.*);

// File: dv/ufs_inode_disk_offset_core_tb.sv
`timescale 1ns / 1ps
// Testbench of the inode number to byte offset core: directed table, then
// random inode numbers under several register settings, checked in order.
// Depends on ufs_ido_pkg and ufs_inode_disk_offset_core.
module ufs_inode_disk_offset_core_tb;

  localparam int INODE_BYTES        = 128;
  localparam int FRAGS_PER_BLK_LOG2 = 3;
  localparam int PIPE_DRAIN         = 100;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [ufs_ido_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [ufs_ido_pkg::CFG_DATA_W-1:0] cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic        out_tuser;

  typedef struct packed {
    logic [63:0] offset;
    logic        err;
  } loc_t;

  // Shadow of the register file
  logic [31:0] sh_ipg, sh_fpg, sh_rot, sh_mask, sh_area;
  logic [10:0] sh_ipb;
  logic [16:0] sh_fbytes;
  logic [47:0] sh_base;

  loc_t        expected_locs[$];
  int          fail_count;
  int          send_idle_pct;
  int          recv_idle_pct;

  ufs_inode_disk_offset_core #(
    .INODE_BYTES       (INODE_BYTES),
    .FRAGS_PER_BLK_LOG2(FRAGS_PER_BLK_LOG2)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("TEST FAILED");
    $finish;
  end

  // Byte offset of one inode under the shadow registers
  function automatic loc_t locate_inode(logic [31:0] ino);
    loc_t        r;
    logic [63:0] grp, idx, sel, start, frag, slot;
    r = '0;
    if (sh_ipg == 0 || sh_fpg == 0 || sh_ipb == 0) begin
      r.err = 1'b1;
      return r;
    end
    grp   = 64'(ino) / 64'(sh_ipg);
    idx   = 64'(ino) % 64'(sh_ipg);
    sel   = grp & 64'(~sh_mask);
    start = 64'(sh_fpg) * grp + 64'(sh_rot) * sel;
    frag  = start + 64'(sh_area) + ((idx / 64'(sh_ipb)) << FRAGS_PER_BLK_LOG2);
    slot  = idx % 64'(sh_ipb);
    r.offset = 64'(sh_base) + frag * 64'(sh_fbytes) + slot * INODE_BYTES;
    return r;
  endfunction

  task automatic write_reg(logic [ufs_ido_pkg::CFG_IDX_W-1:0] idx,
                           logic [ufs_ido_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      ufs_ido_pkg::REG_INODES_PER_GROUP: sh_ipg    = val[31:0];
      ufs_ido_pkg::REG_FRAGS_PER_GROUP:  sh_fpg    = val[31:0];
      ufs_ido_pkg::REG_INODES_PER_BLOCK: sh_ipb    = val[10:0];
      ufs_ido_pkg::REG_ROTATION_DELTA:   sh_rot    = val[31:0];
      ufs_ido_pkg::REG_CYCLE_MASK:       sh_mask   = val[31:0];
      ufs_ido_pkg::REG_INODE_AREA:       sh_area   = val[31:0];
      ufs_ido_pkg::REG_FRAGMENT_BYTES:   sh_fbytes = val[16:0];
      ufs_ido_pkg::REG_SLICE_BASE:       sh_base   = val[47:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    // drop cfg_valid and wait so the next write drives at a later edge
    @(negedge clk);
  endtask

  task automatic write_all(logic [31:0] ipg, logic [31:0] fpg, logic [10:0] ipb,
                           logic [31:0] rot, logic [31:0] msk, logic [31:0] area,
                           logic [16:0] fb, logic [47:0] base);
    write_reg(ufs_ido_pkg::REG_INODES_PER_GROUP, 48'(ipg));
    write_reg(ufs_ido_pkg::REG_FRAGS_PER_GROUP, 48'(fpg));
    write_reg(ufs_ido_pkg::REG_INODES_PER_BLOCK, 48'(ipb));
    write_reg(ufs_ido_pkg::REG_ROTATION_DELTA, 48'(rot));
    write_reg(ufs_ido_pkg::REG_CYCLE_MASK, 48'(msk));
    write_reg(ufs_ido_pkg::REG_INODE_AREA, 48'(area));
    write_reg(ufs_ido_pkg::REG_FRAGMENT_BYTES, 48'(fb));
    write_reg(ufs_ido_pkg::REG_SLICE_BASE, base);
  endtask

  // Send one request; queue its expected location on accept
  task automatic send_inode(logic [31:0] ino);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ino;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_locs.push_back(locate_inode(ino));
    @(negedge clk);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (expected_locs.size() != 0) @(negedge clk);
    repeat (PIPE_DRAIN) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_inode();
    case ($urandom_range(4))
      0: return $urandom_range(255);
      1: return 32'hFFFF_FFFF - $urandom_range(255);
      2: return $urandom_range(sh_ipg == 0 ? 1000 : sh_ipg * 4);
      default: return $urandom;
    endcase
  endfunction

  // Result checking and receiver stalls
  always @(negedge clk) begin
    if (rst_n) out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    loc_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.offset = out_tdata;
      got.err    = out_tuser;
      if (expected_locs.size() == 0) begin
        $error("unexpected result offset=%h err=%b", got.offset, got.err);
        fail_count++;
      end else begin
        want = expected_locs.pop_front();
        if (got.offset !== want.offset) begin
          $error("byte_offset expected %h actual %h", want.offset, got.offset);
          fail_count++;
        end
        if (got.err !== want.err) begin
          $error("config_error expected %b actual %b", want.err, got.err);
          fail_count++;
        end
      end
    end
  end

  typedef struct {
    logic [31:0] ino;
    logic        chk;
    logic [63:0] offset;
    logic        err;
  } row_t;

  row_t dir_rows[$];

  initial begin
    fail_count = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    sh_ipg = 0; sh_fpg = 0; sh_ipb = 0; sh_rot = 0;
    sh_mask = 0; sh_area = 0; sh_fbytes = 0; sh_base = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // After reset every divisor is zero: error, offset 0
    dir_rows = '{
      '{32'd0, 1'b1, 64'd0, 1'b1},
      '{32'hFFFF_FFFF, 1'b1, 64'd0, 1'b1}
    };
    foreach (dir_rows[i]) begin
      send_inode(dir_rows[i].ino);
      if (dir_rows[i].chk) begin
        expected_locs[$] = '{offset: dir_rows[i].offset, err: dir_rows[i].err};
      end
    end
    drain();

    // Each of frags per group, inodes per block and inodes per group, zero alone, flags an error
    write_all(32'd100, 32'd0, 11'd8, 32'd3, 32'd0, 32'd5, 17'd1024, 48'd1000);
    send_inode(32'd1234);
    drain();
    write_reg(ufs_ido_pkg::REG_FRAGS_PER_GROUP, 48'd200);
    write_reg(ufs_ido_pkg::REG_INODE_AREA, 48'd5);
    write_reg(ufs_ido_pkg::REG_INODES_PER_BLOCK, 48'd0);
    send_inode(32'd77);
    drain();
    write_reg(ufs_ido_pkg::REG_INODES_PER_BLOCK, 48'd8);
    write_reg(ufs_ido_pkg::REG_INODES_PER_GROUP, 48'd0);
    send_inode(32'd77);
    drain();

    // Ordinary geometry, then extreme registers with wrap
    write_reg(ufs_ido_pkg::REG_INODES_PER_GROUP, 48'd100);
    dir_rows = '{
      '{32'd0, 1'b0, 64'd0, 1'b0}, '{32'd1, 1'b0, 64'd0, 1'b0},
      '{32'd99, 1'b0, 64'd0, 1'b0}, '{32'd100, 1'b0, 64'd0, 1'b0},
      '{32'd12345, 1'b0, 64'd0, 1'b0}, '{32'hFFFF_FFFF, 1'b0, 64'd0, 1'b0}
    };
    foreach (dir_rows[i]) send_inode(dir_rows[i].ino);
    drain();
    write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 11'h7FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 17'h1FFFF, 48'hFFFF_FFFF_FFFF);
    foreach (dir_rows[i]) send_inode(dir_rows[i].ino);
    drain();
    write_all(32'd1, 32'hFFFF_FFFF, 11'd1, 32'hFFFF_FFFF, 32'd0,
              32'hFFFF_FFFF, 17'd65536, 48'hFFFF_FFFF_FFFF);
    dir_rows = '{
      '{32'd0, 1'b0, 64'd0, 1'b0}, '{32'h5555_5555, 1'b0, 64'd0, 1'b0},
      '{32'hAAAA_AAAA, 1'b0, 64'd0, 1'b0}, '{32'hFFFF_FFFF, 1'b0, 64'd0, 1'b0}
    };
    foreach (dir_rows[i]) send_inode(dir_rows[i].ino);
    drain();
    // Unused high data bits are masked per register
    write_reg(ufs_ido_pkg::REG_INODES_PER_BLOCK, 48'hFFFF_FFFF_F804);
    write_reg(ufs_ido_pkg::REG_FRAGMENT_BYTES, 48'hFFFF_FFFE_0200);
    send_inode(32'd999);
    drain();

    // Random phases: each gets a fresh register setting
    for (int ph = 0; ph < 9; ph++) begin
      case (ph / 3)
        0: begin send_idle_pct = 19; recv_idle_pct = 69; end
        1: begin send_idle_pct = 69; recv_idle_pct = 19; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      if (ph == 8) begin
        write_all(32'd0, $urandom, 11'd4, $urandom, $urandom, $urandom,
                  17'd512, 48'd0);
      end else begin
        write_all(($urandom_range(3) == 0) ? $urandom : $urandom_range(1, 4096),
                  $urandom, ($urandom_range(3) == 0) ? 11'($urandom) :
                  11'($urandom_range(1, 1024)), $urandom, $urandom, $urandom,
                  17'($urandom), 48'({$urandom, $urandom}));
        if (sh_ipb == 0) write_reg(ufs_ido_pkg::REG_INODES_PER_BLOCK, 48'd16);
      end
      for (int k = 0; k < 190; k++) send_inode(rand_inode());
      drain();
    end

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
